>>> sv/deferred_free_slot_allocator_top_defines.svh
// Assertion helpers for the top-level RTL file
`ifndef DEFERRED_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define DEFERRED_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Condition that must hold at every edge out of reset
`define DFSA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next
`define DFSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/dfsa_pkg.sv
package dfsa_pkg;

	// operation codes
	localparam logic [2:0] FN_ALLOC  = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_FLUSH  = 3'd2;
	localparam logic [2:0] FN_LOOKUP = 3'd3;
	localparam logic [2:0] FN_SETPAR = 3'd4;
	localparam logic [2:0] FN_SELECT = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// "no slot" marker in 9-bit signed fields
	localparam logic [8:0] NO_SLOT = 9'h1FF;

	// one slot table entry
	typedef struct packed {
		logic       live;
		logic       pend;
		logic [8:0] parent;
	} ent_t;

	localparam ent_t ENT_FRESH = '{live: 1'b1, pend: 1'b0, parent: NO_SLOT};
	localparam ent_t ENT_FREED = '{live: 1'b0, pend: 1'b0, parent: NO_SLOT};

	// sequencer states
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_CHK   = 9'b000000100,
		S_CHKP  = 9'b000001000,
		S_POP   = 9'b000010000,
		S_WALK  = 9'b000100000,
		S_FLUSH = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_RDP   = 9'b100000000
	} state_t;

endpackage

>>> sv/deferred_free_slot_allocator_top.sv
// Channel | Handshake               | Beat contents
// in      | in_valid / in_ready     | func, index, parent
// out     | out_valid / out_ready   | status, slot, parent_of, is_selected, freed_count
//
// One beat at a time; in_ready is high only while the sequencer is idle.
// Allocate, lookup, set parent and select may wait on registered RAM reads.
// Remove walks the used part of the slot RAM, up to the high-water mark.
// Flush walks the whole pending queue.
// Reset clears counters, selection and sequencer; RAM contents need no clearing pass.
// One result held by a stalled out channel does not block the next input beat.
module deferred_free_slot_allocator_top import dfsa_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic signed [8:0] index,
	input  logic signed [8:0] parent,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [7:0]        slot,
	output logic signed [8:0] parent_of,
	output logic              is_selected,
	output logic [8:0]        freed_count
);

	`include "deferred_free_slot_allocator_top_defines.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > 8) ? CW : 8;
	localparam int EW = $bits(ent_t);

	state_t         state_q;
	logic [2:0]     func_q;
	logic [8:0]     idx_q;
	logic [8:0]     par_q;
	logic [8:0]     selected_q;
	logic [CW-1:0]  hw_q;
	logic [CW-1:0]  ftop_q;
	logic [CW-1:0]  pcnt_q;
	logic [CW-1:0]  cnt_q;
	logic           dv_s1;
	logic [AW-1:0]  daddr_s1;
	ent_t           ent_q;

	// result being built
	logic [1:0]     r_status_q;
	logic [7:0]     r_slot_q;
	logic [8:0]     r_parof_q;
	logic           r_sel_q;
	logic [8:0]     r_freed_q;

	// result fields known in the read state
	logic [1:0]     rd_status;
	logic [7:0]     rd_slot;
	logic           rd_sel;

	// output register
	logic           ov_q;
	logic [1:0]     o_status_q;
	logic [7:0]     o_slot_q;
	logic [8:0]     o_parof_q;
	logic           o_sel_q;
	logic [8:0]     o_freed_q;

	// RAM ports
	logic           sm_we, sm_re;
	logic [AW-1:0]  sm_wa, sm_ra;
	ent_t           sm_wd, sm_rd;
	logic [EW-1:0]  sm_rd_raw;
	logic           fs_we, fs_re;
	logic [AW-1:0]  fs_wa, fs_ra, fs_wd, fs_rd;
	logic           pl_we, pl_re;
	logic [AW-1:0]  pl_wa, pl_ra, pl_wd, pl_rd;

	logic           idx_in_rng, par_in_rng, ent_ok, has_free, out_free;
	logic           budget_ok;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !ov_q || out_ready;

	// range checks against the high-water mark
	assign idx_in_rng = !idx_q[8] && (IW'(idx_q[7:0]) < IW'(hw_q));
	assign par_in_rng = !par_q[8] && (IW'(par_q[7:0]) < IW'(hw_q));
	assign sm_rd      = ent_t'(sm_rd_raw);
	assign ent_ok     = sm_rd.live && !sm_rd.pend;
	assign has_free   = (ftop_q != '0);

	// free plus pending never exceeds used slots, except mid-flush
	assign budget_ok = (state_q == S_FLUSH) ||
		((CW+1)'(ftop_q) + (CW+1)'(pcnt_q) <= (CW+1)'(hw_q));

	// RAM control
	always_comb begin
		sm_we = 1'b0;
		sm_wa = AW'(idx_q[7:0]);
		sm_wd = ENT_FRESH;
		sm_re = 1'b0;
		sm_ra = AW'(idx_q[7:0]);
		fs_we = 1'b0;
		fs_wa = AW'(ftop_q);
		fs_wd = pl_rd;
		fs_re = 1'b0;
		fs_ra = AW'(ftop_q - 1'b1);
		pl_we = 1'b0;
		pl_wa = AW'(pcnt_q);
		pl_wd = AW'(idx_q[7:0]);
		pl_re = 1'b0;
		pl_ra = AW'(cnt_q);
		unique case (state_q)
			S_RD: begin
				unique case (func_q)
					FN_ALLOC: begin
						if (has_free) begin
							fs_re = 1'b1;
						end else if (hw_q < CW'(CAPACITY)) begin
							sm_we = 1'b1;
							sm_wa = AW'(hw_q);
						end
					end
					FN_REMOVE, FN_LOOKUP, FN_SETPAR, FN_SELECT: begin
						sm_re = idx_in_rng;
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				sm_we = 1'b1;
				sm_wa = fs_rd;
			end
			S_CHK: begin
				if (func_q == FN_REMOVE && ent_ok && pcnt_q < CW'(CAPACITY)) begin
					sm_we = 1'b1;
					sm_wd = '{live: sm_rd.live, pend: 1'b1, parent: sm_rd.parent};
					pl_we = 1'b1;
				end else if (func_q == FN_SETPAR && ent_ok) begin
					sm_we = (par_q == NO_SLOT);
					sm_wd = '{live: sm_rd.live, pend: sm_rd.pend, parent: par_q};
				end
			end
			S_RDP: begin
				sm_re = 1'b1;
				sm_ra = AW'(par_q[7:0]);
			end
			S_CHKP: begin
				sm_we = ent_ok;
				sm_wd = '{live: ent_q.live, pend: ent_q.pend, parent: par_q};
			end
			S_WALK: begin
				sm_re = (cnt_q < hw_q);
				sm_ra = AW'(cnt_q);
				sm_we = dv_s1 && (sm_rd.parent == idx_q);
				sm_wa = daddr_s1;
				sm_wd = '{live: sm_rd.live, pend: sm_rd.pend, parent: NO_SLOT};
			end
			S_FLUSH: begin
				pl_re = (cnt_q < pcnt_q);
				sm_we = dv_s1;
				sm_wa = pl_rd;
				sm_wd = ENT_FREED;
				fs_we = dv_s1 && (ftop_q < CW'(CAPACITY));
			end
			default: begin
			end
		endcase
	end

	// result fields known in the read state
	always_comb begin
		rd_status = ST_BAD;
		rd_slot   = '0;
		rd_sel    = 1'b0;
		unique case (func_q)
			FN_ALLOC: begin
				if (!has_free && hw_q < CW'(CAPACITY)) begin
					rd_status = ST_OK;
					rd_slot   = 8'(hw_q);
				end else if (!has_free) begin
					rd_status = ST_FULL;
				end
			end
			FN_REMOVE, FN_LOOKUP, FN_SETPAR, FN_SELECT: begin
				rd_slot = idx_q[7:0];
				rd_sel  = (idx_q == selected_q);
				if (func_q == FN_SELECT && idx_q == NO_SLOT) begin
					rd_status = ST_OK;
				end
			end
			FN_FLUSH: begin
				rd_status = ST_OK;
			end
			default: begin
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			selected_q <= NO_SLOT;
			hw_q       <= '0;
			ftop_q     <= '0;
			pcnt_q     <= '0;
			cnt_q      <= '0;
			dv_s1      <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (ov_q && out_ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_DONE;
					unique case (func_q)
						FN_ALLOC: begin
							if (has_free) begin
								ftop_q  <= ftop_q - 1'b1;
								state_q <= S_POP;
							end else if (hw_q < CW'(CAPACITY)) begin
								hw_q <= hw_q + 1'b1;
							end
						end
						FN_REMOVE, FN_LOOKUP, FN_SETPAR: begin
							if (idx_in_rng) begin
								state_q <= S_CHK;
							end
						end
						FN_SELECT: begin
							if (idx_q == NO_SLOT) begin
								selected_q <= NO_SLOT;
							end else if (idx_in_rng) begin
								state_q <= S_CHK;
							end
						end
						FN_FLUSH: begin
							cnt_q   <= '0;
							dv_s1   <= 1'b0;
							state_q <= S_FLUSH;
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					state_q <= S_DONE;
				end
				S_CHK: begin
					state_q <= S_DONE;
					unique case (func_q)
						FN_REMOVE: begin
							if (ent_ok && pcnt_q < CW'(CAPACITY)) begin
								pcnt_q <= pcnt_q + 1'b1;
								if (selected_q == idx_q) begin
									selected_q <= NO_SLOT;
								end
								cnt_q   <= '0;
								dv_s1   <= 1'b0;
								state_q <= S_WALK;
							end
						end
						FN_SETPAR: begin
							if (ent_ok && par_q != NO_SLOT && par_in_rng) begin
								state_q <= S_RDP;
							end
						end
						FN_SELECT: begin
							if (ent_ok) begin
								selected_q <= idx_q;
							end
						end
						default: begin
						end
					endcase
				end
				S_RDP: begin
					state_q <= S_CHKP;
				end
				S_CHKP: begin
					state_q <= S_DONE;
				end
				S_WALK: begin
					dv_s1 <= (cnt_q < hw_q);
					if (cnt_q < hw_q) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!dv_s1) begin
						state_q <= S_DONE;
					end
				end
				S_FLUSH: begin
					dv_s1 <= (cnt_q < pcnt_q);
					if (cnt_q < pcnt_q) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!dv_s1) begin
						pcnt_q  <= '0;
						state_q <= S_DONE;
					end
					if (dv_s1 && ftop_q < CW'(CAPACITY)) begin
						ftop_q <= ftop_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// beat capture, result build and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			func_q <= func;
			idx_q  <= index;
			par_q  <= parent;
		end
		if (state_q == S_WALK) begin
			daddr_s1 <= AW'(cnt_q);
		end
		unique case (state_q)
			S_RD: begin
				r_status_q <= rd_status;
				r_slot_q   <= rd_slot;
				r_parof_q  <= NO_SLOT;
				r_sel_q    <= rd_sel;
				r_freed_q  <= (func_q == FN_FLUSH) ? 9'(pcnt_q) : 9'd0;
			end
			S_POP: begin
				r_status_q <= ST_OK;
				r_slot_q   <= 8'(fs_rd);
			end
			S_CHK: begin
				ent_q <= sm_rd;
				unique case (func_q)
					FN_REMOVE: begin
						if (ent_ok && pcnt_q < CW'(CAPACITY)) begin
							r_status_q <= ST_OK;
						end
					end
					FN_LOOKUP: begin
						if (ent_ok) begin
							r_status_q <= ST_OK;
							r_parof_q  <= sm_rd.parent;
						end
					end
					FN_SETPAR, FN_SELECT: begin
						if (ent_ok && (func_q == FN_SELECT || par_q == NO_SLOT)) begin
							r_status_q <= ST_OK;
						end
					end
					default: begin
					end
				endcase
			end
			S_CHKP: begin
				if (ent_ok) begin
					r_status_q <= ST_OK;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			o_status_q <= r_status_q;
			o_slot_q   <= r_slot_q;
			o_parof_q  <= r_parof_q;
			o_sel_q    <= r_sel_q;
			o_freed_q  <= r_freed_q;
		end
	end

	assign out_valid   = ov_q;
	assign status      = o_status_q;
	assign slot        = o_slot_q;
	assign parent_of   = o_parof_q;
	assign is_selected = o_sel_q;
	assign freed_count = o_freed_q;

	// slot table: live, pending, parent link
	dfsa_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_slot_ram (
		.clk (clk),
		.we  (sm_we),
		.wa  (sm_wa),
		.wd  (sm_wd),
		.re  (sm_re),
		.ra  (sm_ra),
		.rd  (sm_rd_raw)
	);

	// LIFO of reclaimed slots
	dfsa_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_free_ram (
		.clk (clk),
		.we  (fs_we),
		.wa  (fs_wa),
		.wd  (fs_wd),
		.re  (fs_re),
		.ra  (fs_ra),
		.rd  (fs_rd)
	);

	// queue of removed slots awaiting flush
	dfsa_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_pend_ram (
		.clk (clk),
		.we  (pl_we),
		.wa  (pl_wa),
		.wd  (pl_wd),
		.re  (pl_re),
		.ra  (pl_ra),
		.rd  (pl_rd)
	);

	// checks
	`DFSA_ASSERT_NEXT(a_one_beat, in_valid && in_ready, !in_ready, "second beat taken while busy")
	`DFSA_ASSERT_ALWAYS(a_ftop_cap, ftop_q <= CW'(CAPACITY), "free stack overflow")
	`DFSA_ASSERT_ALWAYS(a_slot_budget, budget_ok, "free plus pending exceeds used slots")
	`DFSA_ASSERT_ALWAYS(a_status_code, !ov_q || o_status_q != 2'd3, "undefined status code")

endmodule

>>> sv/dfsa_ram.sv
// Simple dual port RAM: one write, one registered read
module dfsa_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule
